// ===== design/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared constants and types for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  typedef logic [15:0] unit_t;      // one UTF-16 code unit
  typedef logic [20:0] cpoint_t;    // decoded code point
  typedef logic [2:0]  ucount_t;    // units per byte, 0..4

  localparam unit_t   UNIT_INVALID = 16'h003F;  // '?'
  localparam unit_t   SURR_HIGH    = 16'hD800;
  localparam unit_t   SURR_LOW     = 16'hDC00;
  localparam cpoint_t CP_LIMIT     = 21'h110000;
  localparam cpoint_t BMP_LIMIT    = 21'h010000;

  localparam logic [7:0] BYTE_ASCII_END = 8'h80;
  localparam logic [7:0] BYTE_LEAD_MIN  = 8'hC0;
  localparam logic [7:0] BYTE_LEAD3_MIN = 8'hE0;
  localparam logic [7:0] BYTE_LEAD4_MIN = 8'hF0;
  localparam logic [7:0] BYTE_BAD_MIN   = 8'hF8;

  localparam logic [1:0] CONT_TAG = 2'b10;

endpackage

// ===== design/utf8_to_utf16_transcoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// Decodes a UTF-8 byte stream into UTF-16 code units, with '?' for bad input.
// ----------------------------------------------------------------------------
// The first unit of a byte appears in the cycle after its transaction.
// Throughput: one byte per cycle while out_ready is high and each byte
//   yields at most one unit; a byte yielding more (up to 4) units holds the
//   buffer, and the next byte is taken in the cycle its last unit leaves.
// Reset: synchronous active-low rst_n clears sequence state and output valid.
module utf8_to_utf16_transcoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_run_last,
  output logic        out_text_end
);

  // decoder state
  logic [1:0]          exp_r, exp_nxt;
  logic [1:0]          seen_r, seen_nxt;
  u8u16_pkg::cpoint_t  pv_r, pv_nxt;

  // output buffer: inv_r leading '?' units, then up to two tail units
  logic                valid_r, valid_nxt;
  logic [1:0]          idx_r, idx_nxt;
  u8u16_pkg::ucount_t  n_r, n_nxt;
  u8u16_pkg::ucount_t  inv_r, inv_nxt;
  u8u16_pkg::unit_t    t0_r, t0_nxt;
  u8u16_pkg::unit_t    t1_r, t1_nxt;
  logic                eot_r, eot_nxt;

  // per-byte decode results
  u8u16_pkg::ucount_t  inv_cnt;
  logic [1:0]          tail_cnt;
  u8u16_pkg::unit_t    tail0, tail1;
  u8u16_pkg::ucount_t  unit_cnt;
  logic [1:0]          dexp, dseen;
  u8u16_pkg::cpoint_t  dpv;

  logic                is_cont, fresh;
  logic [1:0]          seen_inc;
  u8u16_pkg::cpoint_t  pv_cat;
  logic [19:0]         supp;

  logic                in_fire, out_fire, last_beat;
  logic [2:0]          idx_ext, sel;

  assign is_cont  = (in_data_byte[7:6] == u8u16_pkg::CONT_TAG);
  assign seen_inc = seen_r + 2'd1;
  assign pv_cat   = {pv_r[14:0], in_data_byte[5:0]};
  assign supp     = pv_cat[19:0] - u8u16_pkg::BMP_LIMIT[19:0];

  always_comb begin
    inv_cnt  = '0;
    tail_cnt = '0;
    tail0    = '0;
    tail1    = '0;
    dexp     = exp_r;
    dseen    = seen_r;
    dpv      = pv_r;
    fresh    = 1'b1;

    if (exp_r != 2'd0) begin
      if (is_cont) begin
        fresh = 1'b0;
        dpv   = pv_cat;
        dseen = seen_inc;
        if (seen_inc == exp_r) begin
          if (exp_r == 2'd3 && pv_cat >= u8u16_pkg::CP_LIMIT) begin
            inv_cnt = 3'd4;
          end else if (pv_cat < u8u16_pkg::BMP_LIMIT) begin
            tail_cnt = 2'd1;
            tail0    = pv_cat[15:0];
          end else begin
            // surrogate pair
            tail_cnt = 2'd2;
            tail0    = u8u16_pkg::SURR_HIGH | {6'd0, supp[19:10]};
            tail1    = u8u16_pkg::SURR_LOW  | {6'd0, supp[9:0]};
          end
          dexp  = '0;
          dseen = '0;
          dpv   = '0;
        end else if (in_end_of_text) begin
          inv_cnt = 3'd1 + {1'b0, seen_inc};
          dexp    = '0;
          dseen   = '0;
          dpv     = '0;
        end
      end else begin
        // sequence broken: flush lead and buffered bytes
        inv_cnt = 3'd1 + {1'b0, seen_r};
        dexp    = '0;
        dseen   = '0;
        dpv     = '0;
      end
    end

    if (fresh) begin
      if (in_data_byte < u8u16_pkg::BYTE_ASCII_END) begin
        tail_cnt = 2'd1;
        tail0    = {8'd0, in_data_byte};
      end else if (in_data_byte < u8u16_pkg::BYTE_LEAD_MIN ||
                   in_data_byte >= u8u16_pkg::BYTE_BAD_MIN) begin
        tail_cnt = 2'd1;
        tail0    = u8u16_pkg::UNIT_INVALID;
      end else begin
        dseen = '0;
        if (in_data_byte < u8u16_pkg::BYTE_LEAD3_MIN) begin
          dexp = 2'd1;
          dpv  = {16'd0, in_data_byte[4:0]};
        end else if (in_data_byte < u8u16_pkg::BYTE_LEAD4_MIN) begin
          dexp = 2'd2;
          dpv  = {17'd0, in_data_byte[3:0]};
        end else begin
          dexp = 2'd3;
          dpv  = {18'd0, in_data_byte[2:0]};
        end
        if (in_end_of_text) begin
          tail_cnt = 2'd1;
          tail0    = u8u16_pkg::UNIT_INVALID;
        end
      end
    end

    if (in_end_of_text) begin
      dexp  = '0;
      dseen = '0;
      dpv   = '0;
    end

    unit_cnt = inv_cnt + {1'b0, tail_cnt};
  end

  // output side
  assign idx_ext   = {1'b0, idx_r};
  assign last_beat = (idx_ext + 3'd1 == n_r);
  assign out_fire  = valid_r & out_ready;
  assign in_ready  = ~valid_r | (out_ready & last_beat);
  assign in_fire   = in_valid & in_ready;
  assign sel       = idx_ext - inv_r;

  assign out_valid     = valid_r;
  assign out_run_last  = last_beat;
  assign out_text_end  = last_beat & eot_r;
  assign out_code_unit = (idx_ext < inv_r) ? u8u16_pkg::UNIT_INVALID :
                         (sel[0] ? t1_r : t0_r);

  always_comb begin
    exp_nxt   = exp_r;
    seen_nxt  = seen_r;
    pv_nxt    = pv_r;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    inv_nxt   = inv_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    eot_nxt   = eot_r;
    if (in_fire) begin
      // buffer is free here: either empty or its last unit leaves now
      exp_nxt   = dexp;
      seen_nxt  = dseen;
      pv_nxt    = dpv;
      valid_nxt = (unit_cnt != 3'd0);
      idx_nxt   = '0;
      n_nxt     = unit_cnt;
      inv_nxt   = inv_cnt;
      t0_nxt    = tail0;
      t1_nxt    = tail1;
      eot_nxt   = in_end_of_text;
    end else if (out_fire) begin
      if (last_beat) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= '0;
      seen_r  <= '0;
      pv_r    <= '0;
      valid_r <= 1'b0;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      exp_r   <= exp_nxt;
      seen_r  <= seen_nxt;
      pv_r    <= pv_nxt;
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inv_r <= inv_nxt;
    t0_r  <= t0_nxt;
    t1_r  <= t1_nxt;
    eot_r <= eot_nxt;
  end

endmodule

// ===== design/u8u16_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the transcoder's output sequencing.
// ----------------------------------------------------------------------------
module u8u16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_code_unit,
  input logic        out_run_last,
  input logic        out_text_end
);

  // stalled transaction holds its unit
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_unit))
    else $error("output unit changed while stalled");

  // end of text only on a byte's last unit
  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_end |-> out_run_last)
    else $error("text_end without run_last");

  // a new byte is only taken when the buffer frees up
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(out_ready && out_run_last) |-> !in_ready)
    else $error("input ready while units still pending");

  // units of one byte leave without a gap
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_last |=> out_valid)
    else $error("unit run broken before run_last");

endmodule

bind utf8_to_utf16_transcoder_top u8u16_checker u_u8u16_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_code_unit (out_code_unit),
  .out_run_last  (out_run_last),
  .out_text_end  (out_text_end)
);
